[design/xed_pkg.sv]
package xed_pkg;

  // longest entity body held after an ampersand
  localparam int ENTITY_SPAN = 8;
  localparam int CNT_W = $clog2(ENTITY_SPAN + 1);
  localparam int IDX_W = $clog2(ENTITY_SPAN);

  // code point arithmetic
  localparam int CODE_W = 21;
  localparam int PROD_W = CODE_W + 4;
  localparam logic [CODE_W-1:0] CODE_MAX = 21'h10FFFF;
  localparam logic [CODE_W-1:0] CODE_SAT = 21'h110000;

  // characters
  localparam logic [7:0] CH_AMP  = 8'h26;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_LT   = 8'h3C;
  localparam logic [7:0] CH_GT   = 8'h3E;
  localparam logic [7:0] CH_QUOT = 8'h22;
  localparam logic [7:0] CH_APOS = 8'h27;

  // datapath operations, one per cycle while the output slot is free
  typedef enum logic [4:0] {
    OP_NONE,
    OP_PASS,
    OP_AMP_END,
    OP_OPEN,
    OP_APPEND,
    OP_SEMI,
    OP_FLUSH_AMP,
    OP_FLUSH_BYTE,
    OP_OVF_AMP,
    OP_OVF_BYTE,
    OP_NAMED,
    OP_REF_START,
    OP_PARSE,
    OP_UTF,
    OP_VERB_AMP,
    OP_VERB_BYTE,
    OP_VERB_SEMI
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic emit_ok;
    logic open;
    logic in_amp;
    logic in_semi;
    logic end_in;
    logic full;
    logic w0_amp;
    logic w1_amp;
    logic cnt_one;
    logic cnt_zero;
    logic name_hit;
    logic is_ref;
    logic ref_empty;
    logic digit_bad;
    logic idx_last;
    logic sat_next;
    logic utf_last;
  } status_t;

endpackage

[design/xml_entity_decoder_unit.sv]
// channel   | direction | tdata          | tlast     | tuser
// ----------+-----------+----------------+-----------+---------
// s_ (in)   | request   | [7:0] in_byte  | text_end  | -
// m_ (out)  | request   | [7:0] out_byte | text_done | run_last
//
// a byte outside an entity, or one that is only held in the window, is taken in the idle state
// a semicolon is taken, then the resolve state also gives a known name
// a reference reads its digits and then emits its utf-8 bytes; verbatim emits the ampersand, window and semicolon
// flush and overflow emit their output bytes after the accepting cycle
// rst is synchronous and clears the state machine, the window count and the output valid
// a stalled output holds the controller; no input is taken while a request's bytes are pending
module xml_entity_decoder_unit
  import xed_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] in_byte
  input  logic       s_tlast,   // text_end
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic       m_tlast,   // text_done
  output logic       m_tuser    // run_last
);

  // command and status between sequencer and datapath
  cmd_t    cmd;
  status_t st;

  // sequencer: picks one datapath operation per cycle, only when output slot is free
  xed_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  // datapath: entity window, name match, reference digit loop, utf-8 encoder, output reg
  xed_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .st       (st),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

[design/xed_datapath.sv]
module xed_datapath
  import xed_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cmd_t       cmd,
  output status_t    st,
  input  logic [7:0] s_tdata,
  input  logic       s_tlast,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,
  output logic       m_tlast,
  output logic       m_tuser
);

  logic [7:0]        win [ENTITY_SPAN];
  logic [CNT_W-1:0]  cnt;
  logic [IDX_W-1:0]  idx;
  logic [CODE_W-1:0] code;
  logic              hex;
  logic              end_flag;
  logic [1:0]        enc;
  logic              open;

  logic [7:0]        rd;
  logic [7:0]        w0, w1, w2, w3;
  logic [7:0]        named_char;
  logic              name_hit;
  logic              hex_tap;
  logic [7:0]        dig;
  logic [3:0]        dval;
  logic              dbad;
  logic [PROD_W-1:0] prod;
  logic              sat_next;
  logic [1:0]        nb_m1;
  logic [7:0]        utf_byte;
  logic              emit;
  logic [7:0]        e_byte;
  logic              e_last;
  logic              e_done;

  assign rd = win[idx];
  assign w0 = win[0];
  assign w1 = win[1];
  assign w2 = win[2];
  assign w3 = win[3];

  // named entities
  always_comb begin
    named_char = CH_AMP;
    name_hit   = 1'b1;
    if (cnt == CNT_W'(3) && w0 == "a" && w1 == "m" && w2 == "p") begin
      named_char = CH_AMP;
    end else if (cnt == CNT_W'(2) && w0 == "l" && w1 == "t") begin
      named_char = CH_LT;
    end else if (cnt == CNT_W'(2) && w0 == "g" && w1 == "t") begin
      named_char = CH_GT;
    end else if (cnt == CNT_W'(4) && w0 == "q" && w1 == "u" && w2 == "o" && w3 == "t") begin
      named_char = CH_QUOT;
    end else if (cnt == CNT_W'(4) && w0 == "a" && w1 == "p" && w2 == "o" && w3 == "s") begin
      named_char = CH_APOS;
    end else begin
      name_hit = 1'b0;
    end
  end

  assign hex_tap = (cnt > CNT_W'(1)) && ((w1 | 8'h20) == "x");

  // digit value of the current byte
  always_comb begin
    dig  = 8'h00;
    dbad = 1'b0;
    if (rd >= "0" && rd <= "9") begin
      dig = rd - "0";
    end else if (hex && rd >= "a" && rd <= "f") begin
      dig = rd - "a" + 8'd10;
    end else if (hex && rd >= "A" && rd <= "F") begin
      dig = rd - "A" + 8'd10;
    end else begin
      dbad = 1'b1;
    end
  end
  assign dval = dig[3:0];

  // code * base + digit, times ten as two shifted adds
  always_comb begin
    if (hex) begin
      prod = {code, 4'b0000};
    end else begin
      prod = {1'b0, code, 3'b000} + {3'b000, code, 1'b0};
    end
    prod = prod + {{(PROD_W-4){1'b0}}, dval};
  end
  assign sat_next = prod > PROD_W'(CODE_MAX);

  // utf-8 length and byte selection
  always_comb begin
    if (code < CODE_W'(21'h80)) nb_m1 = 2'd0;
    else if (code < CODE_W'(21'h800)) nb_m1 = 2'd1;
    else if (code < CODE_W'(21'h10000)) nb_m1 = 2'd2;
    else nb_m1 = 2'd3;
  end

  always_comb begin
    utf_byte = 8'h80 | {2'b00, code[5:0]};
    case (nb_m1)
      2'd0: utf_byte = {1'b0, code[6:0]};
      2'd1: begin
        if (enc == 2'd0) utf_byte = 8'hC0 | {3'b000, code[10:6]};
        else utf_byte = 8'h80 | {2'b00, code[5:0]};
      end
      2'd2: begin
        case (enc)
          2'd0:    utf_byte = 8'hE0 | {4'b0000, code[15:12]};
          2'd1:    utf_byte = 8'h80 | {2'b00, code[11:6]};
          default: utf_byte = 8'h80 | {2'b00, code[5:0]};
        endcase
      end
      default: begin
        case (enc)
          2'd0:    utf_byte = 8'hF0 | {5'b00000, code[20:18]};
          2'd1:    utf_byte = 8'h80 | {2'b00, code[17:12]};
          2'd2:    utf_byte = 8'h80 | {2'b00, code[11:6]};
          default: utf_byte = 8'h80 | {2'b00, code[5:0]};
        endcase
      end
    endcase
  end

  // status to the controller
  assign st.emit_ok   = !m_tvalid || m_tready;
  assign st.open      = open;
  assign st.in_amp    = s_tdata == CH_AMP;
  assign st.in_semi   = s_tdata == CH_SEMI;
  assign st.end_in    = s_tlast;
  assign st.full      = cnt == CNT_W'(ENTITY_SPAN - 1);
  assign st.w0_amp    = w0 == CH_AMP;
  assign st.w1_amp    = w1 == CH_AMP;
  assign st.cnt_one   = cnt == CNT_W'(1);
  assign st.cnt_zero  = cnt == '0;
  assign st.name_hit  = name_hit;
  assign st.is_ref    = (cnt != '0) && (w0 == CH_HASH);
  assign st.ref_empty = (hex_tap ? CNT_W'(2) : CNT_W'(1)) >= cnt;
  assign st.digit_bad = dbad;
  assign st.idx_last  = CNT_W'(idx) == cnt - CNT_W'(1);
  assign st.sat_next  = sat_next;
  assign st.utf_last  = enc == nb_m1;

  // byte to emit for this operation
  always_comb begin
    emit   = 1'b1;
    e_byte = CH_AMP;
    e_last = 1'b0;
    e_done = 1'b0;
    unique case (cmd.op) inside
      OP_PASS: begin
        e_byte = s_tdata;
        e_last = 1'b1;
        e_done = s_tlast;
      end
      OP_AMP_END: begin
        e_last = 1'b1;
        e_done = 1'b1;
      end
      OP_FLUSH_AMP, OP_VERB_AMP: e_byte = CH_AMP;
      OP_FLUSH_BYTE: begin
        e_byte = rd;
        e_last = st.idx_last;
        e_done = st.idx_last;
      end
      OP_OVF_AMP: e_last = st.w0_amp;
      OP_OVF_BYTE: begin
        e_byte = w0;
        e_last = st.cnt_one || st.w1_amp;
      end
      OP_NAMED: begin
        e_byte = named_char;
        e_last = 1'b1;
        e_done = end_flag;
      end
      OP_UTF: begin
        e_byte = utf_byte;
        e_last = st.utf_last;
        e_done = st.utf_last && end_flag;
      end
      OP_VERB_BYTE: e_byte = rd;
      OP_VERB_SEMI: begin
        e_byte = CH_SEMI;
        e_last = 1'b1;
        e_done = end_flag;
      end
      default: emit = 1'b0;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (emit) begin
      m_tdata <= e_byte;
      m_tlast <= e_done;
      m_tuser <= e_last;
    end
  end

  // control state of the window
  always_ff @(posedge clk) begin
    if (rst) begin
      open <= 1'b0;
      cnt  <= '0;
    end else begin
      case (cmd.op) inside
        OP_OPEN: begin
          open <= 1'b1;
          cnt  <= '0;
        end
        OP_APPEND: cnt <= cnt + CNT_W'(1);
        OP_FLUSH_BYTE: begin
          if (st.idx_last) begin
            open <= 1'b0;
            cnt  <= '0;
          end
        end
        OP_OVF_AMP: begin
          if (st.w0_amp) cnt <= cnt - CNT_W'(1);
        end
        OP_OVF_BYTE: begin
          if (st.cnt_one) begin
            open <= 1'b0;
            cnt  <= '0;
          end else if (st.w1_amp) begin
            cnt <= cnt - CNT_W'(2);
          end else begin
            cnt <= cnt - CNT_W'(1);
          end
        end
        OP_NAMED, OP_VERB_SEMI: begin
          open <= 1'b0;
          cnt  <= '0;
        end
        OP_UTF: begin
          if (st.utf_last) begin
            open <= 1'b0;
            cnt  <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // window bytes and parse registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_APPEND: win[cnt[IDX_W-1:0]] <= s_tdata;
      OP_OVF_AMP: begin
        if (st.w0_amp) begin
          for (int i = 0; i < ENTITY_SPAN - 1; i++) win[i] <= win[i+1];
        end
      end
      OP_OVF_BYTE: begin
        if (st.w1_amp && !st.cnt_one) begin
          for (int i = 0; i < ENTITY_SPAN - 2; i++) win[i] <= win[i+2];
        end else begin
          for (int i = 0; i < ENTITY_SPAN - 1; i++) win[i] <= win[i+1];
        end
      end
      default: ;
    endcase

    case (cmd.op) inside
      OP_SEMI: end_flag <= s_tlast;
      OP_FLUSH_AMP, OP_VERB_AMP: idx <= '0;
      OP_FLUSH_BYTE, OP_VERB_BYTE: idx <= idx + IDX_W'(1);
      OP_REF_START: begin
        hex  <= hex_tap;
        idx  <= hex_tap ? IDX_W'(2) : IDX_W'(1);
        code <= '0;
        enc  <= '0;
      end
      OP_PARSE: begin
        code <= sat_next ? CODE_SAT : prod[CODE_W-1:0];
        idx  <= idx + IDX_W'(1);
      end
      OP_UTF: enc <= enc + 2'd1;
      default: ;
    endcase
  end

endmodule

[design/xed_ctrl.sv]
module xed_ctrl
  import xed_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    s_tvalid,
  output logic    s_tready,
  input  status_t st,
  output cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_RESOLVE,
    S_PARSE,
    S_UTF,
    S_VERB_AMP,
    S_VERB_BYTE,
    S_VERB_SEMI,
    S_FLUSH_AMP,
    S_FLUSH_BYTE,
    S_OVF_AMP,
    S_OVF_BYTE
  } state_t;

  state_t state, state_next;

  assign s_tready = (state == S_IDLE) && st.emit_ok;

  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    if (st.emit_ok) begin
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            if (!st.open) begin
              if (!st.in_amp) cmd.op = OP_PASS;
              else if (st.end_in) cmd.op = OP_AMP_END;
              else cmd.op = OP_OPEN;
            end else if (st.in_semi) begin
              cmd.op     = OP_SEMI;
              state_next = S_RESOLVE;
            end else begin
              cmd.op = OP_APPEND;
              if (st.end_in) state_next = S_FLUSH_AMP;
              else if (st.full) state_next = S_OVF_AMP;
            end
          end
        end
        S_RESOLVE: begin
          if (st.name_hit) begin
            cmd.op     = OP_NAMED;
            state_next = S_IDLE;
          end else if (st.is_ref) begin
            cmd.op     = OP_REF_START;
            state_next = st.ref_empty ? S_VERB_AMP : S_PARSE;
          end else begin
            state_next = S_VERB_AMP;
          end
        end
        S_PARSE: begin
          cmd.op = OP_PARSE;
          if (st.digit_bad) state_next = S_VERB_AMP;
          else if (st.idx_last) state_next = st.sat_next ? S_VERB_AMP : S_UTF;
        end
        S_UTF: begin
          cmd.op = OP_UTF;
          if (st.utf_last) state_next = S_IDLE;
        end
        S_VERB_AMP: begin
          cmd.op     = OP_VERB_AMP;
          state_next = st.cnt_zero ? S_VERB_SEMI : S_VERB_BYTE;
        end
        S_VERB_BYTE: begin
          cmd.op = OP_VERB_BYTE;
          if (st.idx_last) state_next = S_VERB_SEMI;
        end
        S_VERB_SEMI: begin
          cmd.op     = OP_VERB_SEMI;
          state_next = S_IDLE;
        end
        S_FLUSH_AMP: begin
          cmd.op     = OP_FLUSH_AMP;
          state_next = S_FLUSH_BYTE;
        end
        S_FLUSH_BYTE: begin
          cmd.op = OP_FLUSH_BYTE;
          if (st.idx_last) state_next = S_IDLE;
        end
        S_OVF_AMP: begin
          cmd.op     = OP_OVF_AMP;
          state_next = st.w0_amp ? S_IDLE : S_OVF_BYTE;
        end
        S_OVF_BYTE: begin
          cmd.op = OP_OVF_BYTE;
          if (st.cnt_one || st.w1_amp) state_next = S_IDLE;
        end
        default: state_next = S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[bench/xed_checker.sv]
`timescale 1ns / 100ps

module xed_checker
  import xed_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  input  logic       s_tready,
  input  logic [7:0] s_tdata,
  input  logic       s_tlast,
  input  logic       m_tvalid,
  input  logic       m_tready,
  input  logic [7:0] m_tdata,
  input  logic       m_tlast,
  input  logic       m_tuser,
  output int         mism_count,
  output int         pending
);

  typedef struct {
    logic [7:0] data;
    logic       run_last;
    logic       text_done;
  } dec_byte_t;

  // decoder state as the predictor sees it
  logic [7:0]  win [ENTITY_SPAN];
  int unsigned win_cnt = 0;
  bit          ent_open = 0;

  logic [7:0]  part_q [$];
  dec_byte_t   dec_q [$];

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mism_count++;
  endtask

  function automatic void put_part(input logic [7:0] b);
    part_q.insert(part_q.size(), b);
  endfunction

  function automatic bit name_match(input string s);
    if (win_cnt != s.len())
      return 0;
    for (int i = 0; i < s.len(); i++)
      if (win[i] != s[i])
        return 0;
    return 1;
  endfunction

  function automatic void put_verbatim();
    put_part(CH_AMP);
    for (int i = 0; i < win_cnt; i++)
      put_part(win[i]);
    put_part(CH_SEMI);
  endfunction

  // numeric reference, decimal or hex, saturating above the code space
  function automatic void decode_ref();
    bit          hex;
    int unsigned idx;
    int unsigned code;
    int unsigned dv;
    logic [7:0]  c;
    hex = (win_cnt > 1) && ((win[1] | 8'h20) == "x");
    idx = hex ? 2 : 1;
    if (idx >= win_cnt) begin
      put_verbatim();
      return;
    end
    code = 0;
    for (; idx < win_cnt; idx++) begin
      c = win[idx];
      if (c >= "0" && c <= "9")
        dv = c - "0";
      else if (hex && c >= "a" && c <= "f")
        dv = c - "a" + 10;
      else if (hex && c >= "A" && c <= "F")
        dv = c - "A" + 10;
      else begin
        put_verbatim();
        return;
      end
      code = code * (hex ? 16 : 10) + dv;
      if (code > CODE_MAX)
        code = CODE_SAT;
    end
    if (code > CODE_MAX) begin
      put_verbatim();
      return;
    end
    if (code < 'h80) begin
      put_part(8'(code));
    end else if (code < 'h800) begin
      put_part(8'hC0 | 8'(code >> 6));
      put_part(8'h80 | 8'(code & 'h3F));
    end else if (code < 'h10000) begin
      put_part(8'hE0 | 8'(code >> 12));
      put_part(8'h80 | 8'((code >> 6) & 'h3F));
      put_part(8'h80 | 8'(code & 'h3F));
    end else begin
      put_part(8'hF0 | 8'(code >> 18));
      put_part(8'h80 | 8'((code >> 12) & 'h3F));
      put_part(8'h80 | 8'((code >> 6) & 'h3F));
      put_part(8'h80 | 8'(code & 'h3F));
    end
  endfunction

  function automatic void resolve_entity();
    if (name_match("amp"))
      put_part(CH_AMP);
    else if (name_match("lt"))
      put_part(CH_LT);
    else if (name_match("gt"))
      put_part(CH_GT);
    else if (name_match("quot"))
      put_part(CH_QUOT);
    else if (name_match("apos"))
      put_part(CH_APOS);
    else if (win_cnt >= 1 && win[0] == CH_HASH)
      decode_ref();
    else
      put_verbatim();
  endfunction

  // works out the decoded bytes caused by one accepted request
  function automatic void predict_decode(input logic [7:0] b, input logic text_end);
    int unsigned p;
    int unsigned rest;
    dec_byte_t   rec;
    part_q.delete();
    if (!ent_open) begin
      if (b == CH_AMP) begin
        ent_open = 1;
        win_cnt = 0;
        if (text_end) begin
          put_part(CH_AMP);
          ent_open = 0;
        end
      end else begin
        put_part(b);
      end
    end else if (b == CH_SEMI) begin
      resolve_entity();
      ent_open = 0;
      win_cnt = 0;
    end else begin
      if (win_cnt < ENTITY_SPAN) begin
        win[win_cnt] = b;
        win_cnt++;
      end
      if (text_end) begin
        put_part(CH_AMP);
        for (int i = 0; i < win_cnt; i++)
          put_part(win[i]);
        ent_open = 0;
        win_cnt = 0;
      end else if (win_cnt >= ENTITY_SPAN) begin
        // no semicolon in the window: release up to the next ampersand
        p = 0;
        put_part(CH_AMP);
        while (p < ENTITY_SPAN && win[p] != CH_AMP) begin
          put_part(win[p]);
          p++;
        end
        if (p < ENTITY_SPAN) begin
          rest = ENTITY_SPAN - p - 1;
          for (int i = 0; i < rest; i++)
            win[i] = win[p + 1 + i];
          win_cnt = rest;
        end else begin
          ent_open = 0;
          win_cnt = 0;
        end
      end
    end
    foreach (part_q[i]) begin
      rec.data = part_q[i];
      rec.run_last = (i == part_q.size() - 1);
      rec.text_done = rec.run_last && text_end;
      dec_q.insert(dec_q.size(), rec);
    end
  endfunction

  always @(posedge clk) begin
    dec_byte_t want;
    if (!rst) begin
      if (s_tvalid && s_tready)
        predict_decode(s_tdata, s_tlast);
      if (m_tvalid && m_tready) begin
        if (dec_q.size() == 0) begin
          report_mismatch($sformatf("unexpected byte %02h", m_tdata));
        end else begin
          want = dec_q.pop_front();
          if (m_tdata !== want.data)
            report_mismatch($sformatf("out_byte %02h, expected %02h", m_tdata, want.data));
          if (m_tuser !== want.run_last)
            report_mismatch($sformatf("run_last %b, expected %b on byte %02h",
                                      m_tuser, want.run_last, want.data));
          if (m_tlast !== want.text_done)
            report_mismatch($sformatf("text_done %b, expected %b on byte %02h",
                                      m_tlast, want.text_done, want.data));
        end
      end
      pending = dec_q.size();
    end
  end

endmodule

[bench/tb.sv]
`timescale 1ns / 100ps

module tb
  import xed_pkg::*;
();

  localparam int RANDOM_BYTES = 300;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct {
    logic [7:0] ch;
    logic       last;
  } text_beat_t;

  logic       clk;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;
  logic       s_tlast = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic       m_tlast;
  logic       m_tuser;

  int         mism_count;
  int         pending;
  int         cycles = 0;
  bit         quiet = 0;   // no idling on either side while set

  text_beat_t text_q [$];

  xml_entity_decoder_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  xed_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .m_tuser    (m_tuser),
    .mism_count (mism_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver stalls about 6 percent of the time
  always @(posedge clk)
    m_tready <= quiet || ($urandom_range(99) >= 6);

  // hang guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic add_beat(input logic [7:0] ch, input logic last);
    text_beat_t t;
    t.ch = ch;
    t.last = last;
    text_q.insert(text_q.size(), t);
  endtask

  task automatic add_str(input string s);
    for (int i = 0; i < s.len(); i++)
      add_beat(s[i], 1'b0);
  endtask

  // random byte that is never a semicolon; ampersands only when allowed
  function automatic logic [7:0] body_byte(input bit amp_ok);
    logic [7:0] c;
    do
      c = 8'($urandom_range(255));
    while (c == CH_SEMI || (!amp_ok && c == CH_AMP));
    return c;
  endfunction

  function automatic logic [7:0] rand_letter();
    logic [7:0] c;
    c = 8'("a" + $urandom_range(25));
    if ($urandom_range(1))
      c = c - 8'h20;
    return c;
  endfunction

  // well-formed numeric reference: body fits the window, so at most 7 bytes
  task automatic add_numeric_ref(input bit hex);
    int unsigned cp;
    int unsigned top;
    string       digits;
    logic [7:0]  c;
    top = hex ? 'hFFFFF : 999999;
    case ($urandom_range(3))
      0: cp = $urandom_range('h7F);
      1: cp = $urandom_range('h7FF, 'h80);
      2: cp = $urandom_range('hFFFF, 'h800);
      default: cp = $urandom_range(top, 'h10000);
    endcase
    digits = hex ? $sformatf("%0h", cp) : $sformatf("%0d", cp);
    // leading zero where the window still has room
    if (digits.len() < (hex ? 5 : 6) && $urandom_range(3) == 0)
      digits = {"0", digits};
    add_beat(CH_AMP, 1'b0);
    add_beat(CH_HASH, 1'b0);
    if (hex)
      add_beat($urandom_range(1) ? "x" : "X", 1'b0);
    for (int i = 0; i < digits.len(); i++) begin
      c = digits[i];
      if (c >= "a" && c <= "f" && $urandom_range(1))
        c = c - 8'h20;
      add_beat(c, 1'b0);
    end
    add_beat(CH_SEMI, 1'b0);
  endtask

  // references that must come out verbatim
  task automatic add_broken_ref();
    int unsigned n;
    add_beat(CH_AMP, 1'b0);
    add_beat(CH_HASH, 1'b0);
    case ($urandom_range(3))
      0: ;  // bare hash
      1: add_beat($urandom_range(1) ? "x" : "X", 1'b0);  // hex prefix, no digits
      2: begin
        // decimal digits with a letter among them
        n = $urandom_range(4);
        for (int i = 0; i < 5; i++)
          add_beat(i == n ? rand_letter() : 8'("0" + $urandom_range(9)), 1'b0);
      end
      default: begin
        // hex digits with a non-hex character among them
        add_beat("x", 1'b0);
        n = $urandom_range(3);
        for (int i = 0; i < 4; i++)
          add_beat(i == n ? 8'("g" + $urandom_range(19)) : 8'("0" + $urandom_range(9)),
                   1'b0);
      end
    endcase
    add_beat(CH_SEMI, 1'b0);
  endtask

  task automatic add_fragment();
    int unsigned n;
    case ($urandom_range(19))
      0, 1, 2, 3: begin
        n = $urandom_range(4, 1);
        repeat (n) add_beat(8'($urandom_range(255)), 1'b0);
      end
      4, 5, 6: begin
        case ($urandom_range(5))
          0: add_str("&amp;");
          1: add_str("&lt;");
          2: add_str("&gt;");
          3: add_str("&quot;");
          4: add_str("&apos;");
          default: add_str("&AMP;");  // names are case sensitive
        endcase
      end
      7, 8: add_numeric_ref(1'b0);
      9, 10: add_numeric_ref(1'b1);
      11, 12: add_broken_ref();
      13, 14: begin
        // unknown entity, copied through with its semicolon
        add_beat(CH_AMP, 1'b0);
        n = $urandom_range(7);
        for (int i = 0; i < n; i++)
          add_beat($urandom_range(2) ? rand_letter() : body_byte(1'b1), 1'b0);
        add_beat(CH_SEMI, 1'b0);
      end
      15, 16: begin
        // window runs out with no semicolon, sometimes with ampersands inside
        add_beat(CH_AMP, 1'b0);
        n = $urandom_range(14, 8);
        for (int i = 0; i < n; i++)
          add_beat($urandom_range(4) == 0 ? CH_AMP : body_byte(1'b0), 1'b0);
      end
      17, 18: begin
        // text ends inside an open window
        add_beat(CH_AMP, 1'b0);
        n = $urandom_range(7);
        for (int i = 0; i < n; i++)
          add_beat(body_byte(1'b1), 1'b0);
        text_q[text_q.size() - 1].last = 1'b1;
      end
      default: add_beat($urandom_range(1) ? CH_AMP : CH_SEMI, 1'b0);
    endcase
    if ($urandom_range(9) == 0)
      text_q[text_q.size() - 1].last = 1'b1;
  endtask

  task automatic send_text();
    text_beat_t t;
    int         sent;
    sent = 0;
    while (text_q.size() != 0) begin
      t = text_q.pop_front();
      if (!quiet)
        while ($urandom_range(99) < 6) begin
          s_tvalid <= 1'b0;
          @(posedge clk);
        end
      s_tvalid <= 1'b1;
      s_tdata <= t.ch;
      s_tlast <= t.last;
      @(posedge clk);
      while (!s_tready)
        @(posedge clk);
      sent++;
      // a long run with both sides streaming
      quiet <= (sent >= 120 && sent < 220);
    end
    s_tvalid <= 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: byte extremes, a name, code point zero, empty entity,
    // window overflow, ampersand as the last byte of a text
    add_beat(8'h00, 1'b0);
    add_beat(8'hFF, 1'b0);
    add_str("&lt;");
    add_str("&#0;");
    add_str("&;");
    add_str("&abcdefgh");
    add_beat(CH_AMP, 1'b1);
    send_text();
    @(posedge clk);

    while (text_q.size() < RANDOM_BYTES)
      add_fragment();
    text_q[text_q.size() - 1].last = 1'b1;
    send_text();

    @(posedge clk);
    while (pending != 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
    if (mism_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

[files.f]
design/xed_pkg.sv
design/xed_datapath.sv
design/xed_ctrl.sv
design/xml_entity_decoder_unit.sv
bench/xed_checker.sv
bench/tb.sv
